/* src/paid_pkg.sv */
`default_nettype none

package paid_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int FUNC_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 3'd0,
        FN_APPEND = 3'd1,
        FN_INSERT = 3'd2,
        FN_DELETE = 3'd3,
        FN_DUMP   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_WRITE,
        ST_DEL_GOT,
        ST_DEL_SHIFT,
        ST_DUMP
    } ctrl_state_t;

    typedef enum logic [2:0] {
        RA_ZERO,
        RA_CNT_M1,
        RA_POS_M1,
        RA_IDX_M2,
        RA_IDX_P1,
        RA_IDX_P2
    } raddr_sel_t;

    typedef enum logic [1:0] {
        WA_CNT,
        WA_IDX,
        WA_POS_M1
    } waddr_sel_t;

    typedef enum logic [1:0] {
        WD_VALUE,
        WD_VAL_REG,
        WD_RDATA
    } wdata_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CNT,
        IDX_POS_M1,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        DS_ZERO,
        DS_RDATA,
        DS_GOT
    } data_sel_t;

    typedef struct packed {
        logic       latch;
        raddr_sel_t raddr_sel;
        logic       we;
        waddr_sel_t waddr_sel;
        wdata_sel_t wdata_sel;
        idx_op_t    idx_op;
        cnt_op_t    cnt_op;
        logic       got_load;
        logic       emit;
        status_t    status;
        data_sel_t  data_sel;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic ins_pos_ok;
        logic ins_at_end;
        logic del_pos_ok;
        logic idx_at_pos;
        logic idx_last;
        logic idx_last2;
    } dp_sts_t;

endpackage

`default_nettype wire

/* src/paid_ram.sv */
`default_nettype none

module paid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/paid_ctrl.sv */
`default_nettype none

module paid_ctrl
    import paid_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [FUNC_W-1:0] func,
    input  wire dp_sts_t           sts,
    output logic                   busy,
    output dp_cmd_t                cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (func_t'(func))
                        FN_INSERT:
                        begin
                            if (sts.ins_pos_ok && !sts.full && !sts.ins_at_end)
                            begin
                                state_next = ST_INS_SHIFT;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (!sts.empty && sts.del_pos_ok)
                            begin
                                state_next = ST_DEL_GOT;
                            end
                        end
                        FN_DUMP:
                        begin
                            if (!sts.empty)
                            begin
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS_SHIFT:
            begin
                if (sts.idx_at_pos)
                begin
                    state_next = ST_INS_WRITE;
                end
            end
            ST_INS_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_DEL_GOT:
            begin
                state_next = sts.idx_last ? ST_IDLE : ST_DEL_SHIFT;
            end
            ST_DEL_SHIFT:
            begin
                if (sts.idx_last2)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (sts.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.raddr_sel = RA_ZERO;
        cmd.waddr_sel = WA_CNT;
        cmd.wdata_sel = WD_VALUE;
        cmd.idx_op    = IDX_HOLD;
        cmd.cnt_op    = CNT_HOLD;
        cmd.status    = STAT_OK;
        cmd.data_sel  = DS_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.last = 1'b1;
                    unique case (func_t'(func))
                        FN_CLEAR:
                        begin
                            cmd.cnt_op = CNT_CLEAR;
                            cmd.emit   = 1'b1;
                        end
                        FN_APPEND:
                        begin
                            cmd.emit = 1'b1;
                            if (sts.full)
                            begin
                                cmd.status = STAT_FULL;
                            end
                            else
                            begin
                                cmd.we     = 1'b1;
                                cmd.cnt_op = CNT_INC;
                            end
                        end
                        FN_INSERT:
                        begin
                            if (!sts.ins_pos_ok)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = STAT_BADPOS;
                            end
                            else if (sts.full)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = STAT_FULL;
                            end
                            else if (sts.ins_at_end)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.we     = 1'b1;
                                cmd.cnt_op = CNT_INC;
                            end
                            else
                            begin
                                cmd.latch     = 1'b1;
                                cmd.raddr_sel = RA_CNT_M1;
                                cmd.idx_op    = IDX_CNT;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = STAT_EMPTY;
                            end
                            else if (!sts.del_pos_ok)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = STAT_BADPOS;
                            end
                            else
                            begin
                                cmd.latch     = 1'b1;
                                cmd.raddr_sel = RA_POS_M1;
                                cmd.idx_op    = IDX_POS_M1;
                            end
                        end
                        FN_DUMP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.raddr_sel = RA_ZERO;
                                cmd.idx_op    = IDX_ZERO;
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_INS_SHIFT:
            begin
                cmd.we        = 1'b1;
                cmd.waddr_sel = WA_IDX;
                cmd.wdata_sel = WD_RDATA;
                if (!sts.idx_at_pos)
                begin
                    cmd.idx_op    = IDX_DEC;
                    cmd.raddr_sel = RA_IDX_M2;
                end
            end
            ST_INS_WRITE:
            begin
                cmd.we        = 1'b1;
                cmd.waddr_sel = WA_POS_M1;
                cmd.wdata_sel = WD_VAL_REG;
                cmd.cnt_op    = CNT_INC;
                cmd.emit      = 1'b1;
                cmd.last      = 1'b1;
            end
            ST_DEL_GOT:
            begin
                cmd.got_load = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.cnt_op   = CNT_DEC;
                    cmd.emit     = 1'b1;
                    cmd.data_sel = DS_RDATA;
                    cmd.last     = 1'b1;
                end
                else
                begin
                    cmd.raddr_sel = RA_IDX_P1;
                end
            end
            ST_DEL_SHIFT:
            begin
                cmd.we        = 1'b1;
                cmd.waddr_sel = WA_IDX;
                cmd.wdata_sel = WD_RDATA;
                if (sts.idx_last2)
                begin
                    cmd.cnt_op   = CNT_DEC;
                    cmd.emit     = 1'b1;
                    cmd.data_sel = DS_GOT;
                    cmd.last     = 1'b1;
                end
                else
                begin
                    cmd.idx_op    = IDX_INC;
                    cmd.raddr_sel = RA_IDX_P2;
                end
            end
            ST_DUMP:
            begin
                cmd.emit     = 1'b1;
                cmd.data_sel = DS_RDATA;
                cmd.last     = sts.idx_last;
                if (!sts.idx_last)
                begin
                    cmd.idx_op    = IDX_INC;
                    cmd.raddr_sel = RA_IDX_P1;
                end
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/paid_dp.sv */
`default_nettype none

module paid_dp
    import paid_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dp_cmd_t                 cmd,
    input  wire logic [POS_W-1:0]        position,
    input  wire logic signed [VAL_W-1:0] value,
    output dp_sts_t                      sts,
    output logic                         valid,
    output logic [1:0]                   status,
    output logic signed [VAL_W-1:0]      data,
    output logic [CNT_W-1:0]             count_now,
    output logic                         last
);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [POS_W-1:0]        pos_reg;
    logic [VAL_W-1:0]        val_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic [ADDR_W-1:0]       idx_next;
    logic [VAL_W-1:0]        got_reg;
    logic                    valid_reg;
    logic [1:0]              status_reg;
    logic signed [VAL_W-1:0] data_reg;
    logic [CNT_W-1:0]        count_now_reg;
    logic                    last_reg;

    logic [ADDR_W-1:0]       raddr;
    logic [ADDR_W-1:0]       waddr;
    logic [VAL_W-1:0]        wdata;
    logic [VAL_W-1:0]        rdata;
    logic [CNT_W-1:0]        cnt_m1;
    logic [POS_W-1:0]        pos_in_m1;
    logic [POS_W-1:0]        pos_reg_m1;
    logic [CNT_W:0]          cnt_p1;
    logic [CNT_W-1:0]        idx_ext;
    logic [VAL_W-1:0]        data_mux;

    assign cnt_m1     = count_reg - CNT_W'(1);
    assign cnt_p1     = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign pos_in_m1  = position - POS_W'(1);
    assign pos_reg_m1 = pos_reg - POS_W'(1);
    assign idx_ext    = CNT_W'(idx_reg);

    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg >= CNT_W'(DEPTH));
    assign sts.ins_pos_ok = (position != '0) && ({1'b0, position} <= cnt_p1);
    assign sts.ins_at_end = ({1'b0, position} == cnt_p1);
    assign sts.del_pos_ok = (position != '0) && (position <= count_reg);
    assign sts.idx_at_pos = (idx_ext == pos_reg);
    assign sts.idx_last   = (idx_ext + CNT_W'(1) == count_reg);
    assign sts.idx_last2  = (idx_ext + CNT_W'(2) == count_reg);

    always_comb
    begin
        case (cmd.raddr_sel)
            RA_CNT_M1: raddr = cnt_m1[ADDR_W-1:0];
            RA_POS_M1: raddr = pos_in_m1[ADDR_W-1:0];
            RA_IDX_M2: raddr = idx_reg - ADDR_W'(2);
            RA_IDX_P1: raddr = idx_reg + ADDR_W'(1);
            RA_IDX_P2: raddr = idx_reg + ADDR_W'(2);
            default:   raddr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.waddr_sel)
            WA_IDX:    waddr = idx_reg;
            WA_POS_M1: waddr = pos_reg_m1[ADDR_W-1:0];
            default:   waddr = count_reg[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        case (cmd.wdata_sel)
            WD_VAL_REG: wdata = val_reg;
            WD_RDATA:   wdata = rdata;
            default:    wdata = value;
        endcase
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_CNT:    idx_next = count_reg[ADDR_W-1:0];
            IDX_POS_M1: idx_next = pos_in_m1[ADDR_W-1:0];
            IDX_ZERO:   idx_next = '0;
            IDX_INC:    idx_next = idx_reg + ADDR_W'(1);
            IDX_DEC:    idx_next = idx_reg - ADDR_W'(1);
            default:    idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_CLEAR: count_next = '0;
            CNT_INC:   count_next = count_reg + CNT_W'(1);
            CNT_DEC:   count_next = cnt_m1;
            default:   count_next = count_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.data_sel)
            DS_RDATA: data_mux = rdata;
            DS_GOT:   data_mux = got_reg;
            default:  data_mux = '0;
        endcase
    end

    paid_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.latch)
        begin
            pos_reg <= position;
            val_reg <= value;
        end
        if (cmd.got_load)
        begin
            got_reg <= rdata;
        end
        if (cmd.emit)
        begin
            status_reg    <= cmd.status;
            data_reg      <= data_mux;
            count_now_reg <= count_next;
            last_reg      <= cmd.last;
        end
    end

    assign valid     = valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign count_now = count_now_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

/* src/positional_array_insert_delete.sv */
// Ordered list of up to DEPTH signed 32-bit values with clear, append,
// insert-at-position, delete-at-position and dump commands.
// Input: a command transfer happens on a clock edge with start high and
// busy low; func, position and value are sampled there.
// Output: each result is held on status/data/count_now/last for one cycle
// while valid is high. The receiver cannot stall; results are never held.
// Every result register is loaded in the cycle after the decision.
//   Clear, append, unused codes, rejected commands and insert at count+1:
//   result in the next cycle, busy stays low, one command per cycle.
//   Insert at p (p <= count): the entries from p upward move up one place,
//   top first, through the single RAM write port; then value is written at p.
//   Delete at p: read of the entry, then each entry above it moves down
//   one place; the deleted entry is the result.
//   Dump: count results on consecutive cycles, last on the final one;
//   busy stays high while the entries are read out.
// Reset: count goes to zero and the controller to idle. RAM contents are
// not cleared; entries at or above the count are never read.
`default_nettype none

module positional_array_insert_delete
    import paid_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [FUNC_W-1:0]       func,
    input  wire logic [POS_W-1:0]        position,
    input  wire logic signed [VAL_W-1:0] value,
    output logic                         valid,
    output logic [1:0]                   status,
    output logic signed [VAL_W-1:0]      data,
    output logic [CNT_W-1:0]             count_now,
    output logic                         last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    paid_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    paid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .position  (position),
        .value     (value),
        .sts       (sts),
        .valid     (valid),
        .status    (status),
        .data      (data),
        .count_now (count_now),
        .last      (last)
    );

endmodule

`default_nettype wire

/* src/paid_checker.sv */
`default_nettype none

module paid_checker
    import paid_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic [FUNC_W-1:0]       func,
    input wire logic                    valid,
    input wire logic [1:0]              status,
    input wire logic signed [VAL_W-1:0] data,
    input wire logic [CNT_W-1:0]        count_now,
    input wire logic                    last
);

    // error results are always single
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != STAT_OK |-> last)
        else $error("error result without last");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == STAT_EMPTY |-> count_now == '0 && data == '0)
        else $error("empty status with nonzero count or data");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> count_now <= CNT_W'(DEPTH))
        else $error("count above depth");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == FN_CLEAR |=> valid && last && count_now == '0)
        else $error("clear did not complete");

    // a dump streams without gaps
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |=> valid)
        else $error("gap in dump stream");

endmodule

bind positional_array_insert_delete paid_checker u_paid_checker (.*);

`default_nettype wire

/* dv/positional_array_insert_delete_tb.sv */
`timescale 1ns / 1ps

module positional_array_insert_delete_tb;
    import paid_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int RANDOM_ITEMS  = 470;

    typedef struct {
        logic [FUNC_W-1:0]       fn;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        int                      gap;
        bit                      drain;
    } cmd_t;

    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] data;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } reply_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [FUNC_W-1:0]       func = '0;
    logic [POS_W-1:0]        position = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic                    busy;
    logic                    valid;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] data;
    logic [CNT_W-1:0]        count_now;
    logic                    last;

    cmd_t   cmd_q[$];
    reply_t reply_q[$];

    logic signed [VAL_W-1:0] list_mirror[DEPTH];
    int                      list_len = 0;
    int                      gen_len = 0;
    int                      error_count = 0;
    int                      gap_left = 0;
    int                      settle_left = SETTLE_CYCLES;

    positional_array_insert_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .position  (position),
        .value     (value),
        .valid     (valid),
        .status    (status),
        .data      (data),
        .count_now (count_now),
        .last      (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic push_reply(status_t s, logic signed [VAL_W-1:0] d, logic l);
        reply_t r;
        r.status = s;
        r.data   = d;
        r.count  = CNT_W'(list_len);
        r.last   = l;
        reply_q.push_back(r);
    endtask

    task automatic apply_command(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p_in,
                                 logic signed [VAL_W-1:0] v);
        int p;
        logic signed [VAL_W-1:0] got;
        p = int'(p_in);
        case (f)
            FN_CLEAR:
            begin
                list_len = 0;
                push_reply(STAT_OK, '0, 1'b1);
            end
            FN_APPEND:
            begin
                if (list_len >= DEPTH)
                    push_reply(STAT_FULL, '0, 1'b1);
                else
                begin
                    list_mirror[list_len] = v;
                    list_len++;
                    push_reply(STAT_OK, '0, 1'b1);
                end
            end
            FN_INSERT:
            begin
                if (p < 1 || p > list_len + 1)
                    push_reply(STAT_BADPOS, '0, 1'b1);
                else if (list_len >= DEPTH)
                    push_reply(STAT_FULL, '0, 1'b1);
                else
                begin
                    for (int i = list_len; i > p - 1; i--)
                        list_mirror[i] = list_mirror[i-1];
                    list_mirror[p-1] = v;
                    list_len++;
                    push_reply(STAT_OK, '0, 1'b1);
                end
            end
            FN_DELETE:
            begin
                if (list_len == 0)
                    push_reply(STAT_EMPTY, '0, 1'b1);
                else if (p < 1 || p > list_len)
                    push_reply(STAT_BADPOS, '0, 1'b1);
                else
                begin
                    got = list_mirror[p-1];
                    for (int i = p - 1; i + 1 < list_len; i++)
                        list_mirror[i] = list_mirror[i+1];
                    list_len--;
                    push_reply(STAT_OK, got, 1'b1);
                end
            end
            FN_DUMP:
            begin
                if (list_len == 0)
                    push_reply(STAT_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < list_len; i++)
                        push_reply(STAT_OK, list_mirror[i], i + 1 == list_len);
            end
            default:
                push_reply(STAT_OK, '0, 1'b1);
        endcase
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t nxt;
        if (!rst_n)
        begin
            start       <= 1'b0;
            func        <= '0;
            position    <= '0;
            value       <= '0;
            gap_left    = 0;
            settle_left = SETTLE_CYCLES;
        end
        else if (!start || !busy)
        begin
            if (start)
                apply_command(func, position, value);
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cmd_q.size() == 0)
                start <= 1'b0;
            else if (cmd_q[0].drain)
            begin
                start <= 1'b0;
                if (reply_q.size() == 0 && !busy)
                begin
                    if (settle_left > 0)
                        settle_left--;
                    else
                    begin
                        void'(cmd_q.pop_front());
                        settle_left = SETTLE_CYCLES;
                    end
                end
            end
            else if (cmd_q[0].gap > 0)
            begin
                gap_left = cmd_q[0].gap - 1;
                cmd_q[0].gap = 0;
                start <= 1'b0;
            end
            else
            begin
                nxt = cmd_q.pop_front();
                start    <= 1'b1;
                func     <= nxt.fn;
                position <= nxt.pos;
                value    <= nxt.val;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        reply_t exp_r;
        if (rst_n && valid)
        begin
            if (reply_q.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d data=%0d count=%0d last=%0d",
                         $time, status, data, count_now, last);
                error_count++;
            end
            else
            begin
                exp_r = reply_q.pop_front();
                if (status !== exp_r.status || data !== exp_r.data ||
                    count_now !== exp_r.count || last !== exp_r.last)
                begin
                    $display("%0t: mismatch expected status=%0d data=%0d count=%0d last=%0d",
                             $time, exp_r.status, exp_r.data, exp_r.count, exp_r.last);
                    $display("%0t:          actual   status=%0d data=%0d count=%0d last=%0d",
                             $time, status, data, count_now, last);
                    error_count++;
                end
            end
        end
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    task automatic add_cmd(logic [FUNC_W-1:0] f, int p, logic signed [VAL_W-1:0] v,
                           int gap);
        cmd_t c;
        c.fn    = f;
        c.pos   = POS_W'(p);
        c.val   = v;
        c.gap   = gap;
        c.drain = 1'b0;
        cmd_q.push_back(c);
        case (f)
            FN_CLEAR:  gen_len = 0;
            FN_APPEND: if (gen_len < DEPTH) gen_len++;
            FN_INSERT: if (p >= 1 && p <= gen_len + 1 && gen_len < DEPTH) gen_len++;
            FN_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
            default: ;
        endcase
    endtask

    task automatic add_drain();
        cmd_t c;
        c.fn    = FN_CLEAR;
        c.pos   = '0;
        c.val   = '0;
        c.gap   = 0;
        c.drain = 1'b1;
        cmd_q.push_back(c);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 32'sh7FFF_FFFF;
        else if (r == 1)
            return 32'sh8000_0000;
        else if (r == 2)
            return '0;
        else
            return $urandom();
    endfunction

    task automatic add_random_cmd(int bias, bit quiet);
        int r;
        int g;
        r = $urandom_range(0, 99);
        g = pick_gap(quiet);
        if (r < 2)
            add_cmd(FN_CLEAR, $urandom_range(0, 127), pick_value(), g);
        else if (r < 5)
            add_cmd(FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)),
                    $urandom_range(0, 127), pick_value(), g);
        else if (r < 10)
            add_cmd(FN_DUMP, $urandom_range(0, 127), pick_value(), g);
        else if (r < 20)
        begin
            if ($urandom_range(0, 1) == 0)
                add_cmd(FN_INSERT, ($urandom_range(0, 3) == 0) ? 0 :
                        $urandom_range(gen_len + 2, 127), pick_value(), g);
            else
                add_cmd(FN_DELETE, ($urandom_range(0, 3) == 0) ? 0 :
                        $urandom_range(gen_len + 1, 127), pick_value(), g);
        end
        else
        begin
            r = $urandom_range(0, 2);
            if (bias == 0)
                r = $urandom_range(0, 1);
            else if (bias == 1)
                r = 2;
            if (r == 0)
                add_cmd(FN_APPEND, $urandom_range(0, 127), pick_value(), g);
            else if (r == 1)
                add_cmd(FN_INSERT, $urandom_range(1, gen_len + 1), pick_value(), g);
            else
                add_cmd(FN_DELETE, (gen_len == 0) ? 1 : $urandom_range(1, gen_len),
                        pick_value(), g);
        end
    endtask

    initial
    begin
        int made;
        int run_len;
        int bias;
        bit quiet;
        bit drained;

        // directed
        add_cmd(FN_CLEAR, 0, '0, 0);
        add_cmd(FN_DUMP, 0, '0, 0);
        add_cmd(FN_DELETE, 1, '0, 0);
        add_cmd(FN_DELETE, 0, '0, 2);
        add_cmd(FN_APPEND, 0, 32'sh7FFF_FFFF, 0);
        add_cmd(FN_APPEND, 127, 32'sh8000_0000, 0);
        add_cmd(FN_INSERT, 1, -32'sd1, 0);
        add_cmd(FN_INSERT, 4, '0, 0);
        add_cmd(FN_INSERT, 2, 32'sh5A5A_A5A5, 1);
        add_cmd(FN_INSERT, 0, 32'sh1234_5678, 0);
        add_cmd(FN_INSERT, 127, 32'sh1234_5678, 0);
        add_cmd(FN_INSERT, 7, 32'sh1234_5678, 0);
        add_cmd(FN_DELETE, 0, '0, 0);
        add_cmd(FN_DELETE, 6, '0, 0);
        add_cmd(FN_DELETE, 3, '0, 0);
        add_cmd(FN_DELETE, 4, '0, 3);
        add_cmd(FN_DELETE, 1, '0, 0);
        add_cmd(FN_DUMP, 0, '0, 0);
        add_cmd(FN_SPARE_LO, 127, 32'shFFFF_FFFF, 0);
        add_cmd(FN_SPARE_MID, 1, '0, 0);
        add_cmd(FN_SPARE_HI, 64, 32'sh8000_0000, 0);
        add_cmd(FN_APPEND, 0, 32'sh0F0F_0F0F, 0);
        add_cmd(FN_DUMP, 127, '0, 0);
        add_cmd(FN_CLEAR, 127, 32'shFFFF_FFFF, 0);
        add_drain();

        // random episodes; the first one fills the list to overflow
        made = 0;
        drained = 1'b0;
        bias = 0;
        while (made < RANDOM_ITEMS)
        begin
            run_len = (made == 0) ? 90 : $urandom_range(20, 80);
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < run_len && made < RANDOM_ITEMS; i++)
            begin
                add_random_cmd(bias, quiet);
                made++;
            end
            if (!drained && made >= RANDOM_ITEMS / 2)
            begin
                add_drain();
                drained = 1'b1;
            end
            bias = $urandom_range(0, 2);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start)
            @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
